// ----- hw/rtl/cmmre_pkg.sv -----
package cmmre_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int MAX_W         = 15;
    localparam int RMS_W         = 16;
    localparam int SQUARE_W      = 31;
    localparam int SUM_W         = 46;
    localparam int COUNT_W       = 16;
    localparam int MEAN_W        = 31;
    localparam int ROOT_CALC_W   = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int MAX_COLUMN_SAMPLES_DEFAULT = 32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in_column;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] column_min;
        logic        [MAX_W-1:0]    column_max;
        logic        [RMS_W-1:0]    column_rms;
    } out_t;

    // One closed column handed from the front end to the back end.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] col_min;
        logic        [MAX_W-1:0]    col_max;
        logic        [SUM_W-1:0]    col_sum;
        logic        [COUNT_W-1:0]  col_count;
    } col_t;

endpackage

// ----- hw/rtl/cmmre_front.sv -----
module cmmre_front #(
    parameter int MAX_SAMPLES = cmmre_pkg::MAX_COLUMN_SAMPLES_DEFAULT,
    parameter int DEPTH       = cmmre_pkg::QUEUE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  cmmre_pkg::in_t             s_data,
    input  logic [$clog2(DEPTH+1)-1:0] q_count,
    output logic                       push,
    output cmmre_pkg::col_t            push_data
);

    localparam int CW = $clog2(DEPTH+1);

    logic signed [cmmre_pkg::SAMPLE_W-1:0] min_reg;
    logic        [cmmre_pkg::MAX_W-1:0]    max_reg;
    logic        [cmmre_pkg::COUNT_W-1:0]  count_reg;
    logic        [cmmre_pkg::SUM_W-1:0]    sum_reg;
    logic        [cmmre_pkg::SQUARE_W-1:0] sq_reg;
    logic                                  sq_valid_reg;
    logic                                  close_d_reg;
    logic signed [cmmre_pkg::SAMPLE_W-1:0] hold_min_reg;
    logic        [cmmre_pkg::MAX_W-1:0]    hold_max_reg;
    logic        [cmmre_pkg::COUNT_W-1:0]  hold_count_reg;

    logic                                  accept;
    logic                                  close;
    logic signed [2*cmmre_pkg::SAMPLE_W-1:0] prod;
    logic signed [cmmre_pkg::SAMPLE_W-1:0] new_min;
    logic        [cmmre_pkg::MAX_W-1:0]    new_max;
    logic        [cmmre_pkg::COUNT_W-1:0]  count_inc;
    logic        [cmmre_pkg::SUM_W-1:0]    sum_add;

    // Reserve a queue slot for a close that is still in the sum stage.
    assign s_ready = ({1'b0, q_count} + {{CW{1'b0}}, close_d_reg}) < (CW+1)'(DEPTH);
    assign accept  = s_valid && s_ready;

    assign prod      = s_data.sample * s_data.sample;
    assign new_min   = (s_data.sample < min_reg) ? s_data.sample : min_reg;
    assign new_max   = (s_data.sample > $signed({1'b0, max_reg}))
                       ? s_data.sample[cmmre_pkg::MAX_W-1:0] : max_reg;
    assign count_inc = count_reg + 1'b1;
    assign close     = s_data.last_in_column ||
                       (count_inc >= cmmre_pkg::COUNT_W'(MAX_SAMPLES));
    assign sum_add   = sum_reg + {{(cmmre_pkg::SUM_W-cmmre_pkg::SQUARE_W){1'b0}}, sq_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg      <= '0;
            max_reg      <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            sq_valid_reg <= 1'b0;
            close_d_reg  <= 1'b0;
        end else begin
            sq_valid_reg <= accept;
            close_d_reg  <= accept && close;
            if (accept) begin
                if (close) begin
                    min_reg   <= '0;
                    max_reg   <= '0;
                    count_reg <= '0;
                end else begin
                    min_reg   <= new_min;
                    max_reg   <= new_max;
                    count_reg <= count_inc;
                end
            end
            if (sq_valid_reg) begin
                sum_reg <= close_d_reg ? '0 : sum_add;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sq_reg <= prod[cmmre_pkg::SQUARE_W-1:0];
            if (close) begin
                hold_min_reg   <= new_min;
                hold_max_reg   <= new_max;
                hold_count_reg <= count_inc;
            end
        end
    end

    assign push                = close_d_reg;
    assign push_data.col_min   = hold_min_reg;
    assign push_data.col_max   = hold_max_reg;
    assign push_data.col_sum   = sum_add;
    assign push_data.col_count = hold_count_reg;

endmodule

// ----- hw/rtl/cmmre_fifo.sv -----
module cmmre_fifo #(
    parameter int DEPTH = cmmre_pkg::QUEUE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  cmmre_pkg::col_t            push_data,
    input  logic                       pop,
    output cmmre_pkg::col_t            pop_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    cmmre_pkg::col_t   mem [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              do_push;
    logic              do_pop;

    assign do_push = push && (count_reg != CW'(DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg];
    assign count    = count_reg;

endmodule

// ----- hw/rtl/cmmre_back.sv -----
module cmmre_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_empty,
    input  cmmre_pkg::col_t q_data,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output cmmre_pkg::out_t m_data
);

    localparam int SUM_W   = cmmre_pkg::SUM_W;
    localparam int REM_W   = cmmre_pkg::COUNT_W + 1;
    localparam int DCNT_W  = $clog2(SUM_W);
    localparam int RW      = cmmre_pkg::ROOT_CALC_W;
    localparam int MEAN_W  = cmmre_pkg::MEAN_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SQRT = 4'b0100,
        ST_OUT  = 4'b1000
    } back_state_t;

    back_state_t                            state_reg, state_next;
    logic [REM_W-1:0]                       rem_reg, rem_next;
    logic [SUM_W-1:0]                       quo_reg, quo_next;
    logic [cmmre_pkg::COUNT_W-1:0]          div_reg, div_next;
    logic [DCNT_W-1:0]                      dcnt_reg, dcnt_next;
    logic [RW-1:0]                          v_reg, v_next;
    logic [RW-1:0]                          root_reg, root_next;
    logic [RW-1:0]                          bit_reg, bit_next;
    logic signed [cmmre_pkg::SAMPLE_W-1:0]  min_reg, min_next;
    logic [cmmre_pkg::MAX_W-1:0]            max_reg, max_next;

    logic [REM_W-1:0]                       rem_shift;
    logic [SUM_W-1:0]                       quo_step;
    logic [REM_W-1:0]                       rem_step;
    logic [MEAN_W-1:0]                      mean;
    logic [RW-1:0]                          trial;

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        rem_shift = {rem_reg[REM_W-2:0], quo_reg[SUM_W-1]};
        if (rem_shift >= {1'b0, div_reg}) begin
            rem_step = rem_shift - {1'b0, div_reg};
            quo_step = {quo_reg[SUM_W-2:0], 1'b1};
        end else begin
            rem_step = rem_shift;
            quo_step = {quo_reg[SUM_W-2:0], 1'b0};
        end
        // Clamp the mean to 31 bits before the root.
        if (|quo_step[SUM_W-1:MEAN_W]) begin
            mean = '1;
        end else begin
            mean = quo_step[MEAN_W-1:0];
        end
    end

    assign trial = root_reg + bit_reg;

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        dcnt_next  = dcnt_reg;
        v_next     = v_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    rem_next   = '0;
                    quo_next   = q_data.col_sum;
                    div_next   = q_data.col_count;
                    dcnt_next  = DCNT_W'(SUM_W-1);
                    min_next   = q_data.col_min;
                    max_next   = q_data.col_max;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == '0) begin
                    v_next     = {{(RW-MEAN_W){1'b0}}, mean};
                    root_next  = '0;
                    bit_next   = RW'(1) << (RW-2);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (bit_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    if (v_reg >= trial) begin
                        v_next    = v_reg - trial;
                        root_next = (root_reg >> 1) + bit_reg;
                    end else begin
                        root_next = root_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        div_reg  <= div_next;
        dcnt_reg <= dcnt_next;
        v_reg    <= v_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        min_reg  <= min_next;
        max_reg  <= max_next;
    end

    assign m_valid           = (state_reg == ST_OUT);
    assign m_data.column_min = min_reg;
    assign m_data.column_max = max_reg;
    assign m_data.column_rms = root_reg[cmmre_pkg::RMS_W-1:0];

endmodule

// ----- hw/rtl/column_min_max_rms_envelope_top.sv -----
// Column min / max / RMS envelope.
//
// s_valid / s_ready / s_data carry one signed Q1.15 sample per transfer,
// with last_in_column marking the end of a display column. A column also
// closes on its own when MAX_COLUMN_SAMPLES samples have been taken.
// m_valid / m_ready / m_data carry one result per column: the minimum
// (never above zero), the maximum (never below zero) and the floor RMS.
//
// Samples are taken at one per cycle while s_ready is high. The square
// and the running sum sit in a two-stage front end; a closed column goes
// into a two-entry queue. The back end works one column at a time:
// restoring division, then square root, then the result waits in the
// output register. It takes the next column from the queue only after
// the result has been accepted. If the receiver stalls, the result holds,
// the queue fills, and s_ready drops only when no queue slot is left for
// another closing sample.
// Reset clears the running values, the queue and the output; no result is
// pending afterwards.
module column_min_max_rms_envelope_top #(
    parameter int MAX_COLUMN_SAMPLES = cmmre_pkg::MAX_COLUMN_SAMPLES_DEFAULT,
    parameter int QUEUE_DEPTH        = cmmre_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  cmmre_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output cmmre_pkg::out_t m_data
);

    localparam int CW = $clog2(QUEUE_DEPTH+1);

    logic            push;
    cmmre_pkg::col_t push_data;
    logic            q_pop;
    cmmre_pkg::col_t q_data;
    logic [CW-1:0]   q_count;

    cmmre_front #(
        .MAX_SAMPLES (MAX_COLUMN_SAMPLES),
        .DEPTH       (QUEUE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    cmmre_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .count     (q_count)
    );

    cmmre_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_count == '0),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count == CW'(QUEUE_DEPTH)) |-> !s_ready)
        else $error("input ready while queue is full");

    a_no_lost_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_count != CW'(QUEUE_DEPTH)))
        else $error("closed column pushed into a full queue");

    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.column_min <= 0) && (m_data.column_rms <= 16'd32768)))
        else $error("result out of range");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int COLUMN_BOUND = cmmre_pkg::MAX_COLUMN_SAMPLES_DEFAULT;
    localparam int LONG_COLUMN  = 128;
    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 150;
    localparam int REPORT_LIMIT = 10;

    // Mirrors the column reduction and holds the results still owed by the block.
    class column_envelope;
        logic signed [cmmre_pkg::SAMPLE_W-1:0] low_mark;
        logic signed [cmmre_pkg::SAMPLE_W-1:0] high_mark;
        logic        [cmmre_pkg::SUM_W-1:0]    energy;
        int unsigned                           taken;
        cmmre_pkg::out_t                       expected_columns[$];
        int unsigned                           failures;

        function new();
            failures = 0;
            clear_column();
        endfunction

        function void clear_column();
            low_mark  = '0;
            high_mark = '0;
            energy    = '0;
            taken     = 0;
        endfunction

        function logic [cmmre_pkg::RMS_W-1:0] floor_root(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 16; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            return r[cmmre_pkg::RMS_W-1:0];
        endfunction

        function void take_sample(cmmre_pkg::in_t item);
            longint          sq;
            longint unsigned mean;
            cmmre_pkg::out_t col;
            sq = longint'(item.sample) * longint'(item.sample);
            if (item.sample < low_mark) low_mark = item.sample;
            if (item.sample > high_mark) high_mark = item.sample;
            energy = energy + sq[cmmre_pkg::SUM_W-1:0];
            taken++;
            if (item.last_in_column || taken >= COLUMN_BOUND) begin
                mean           = longint'(energy) / longint'(taken);
                col.column_min = low_mark;
                col.column_max = high_mark[cmmre_pkg::MAX_W-1:0];
                col.column_rms = floor_root(mean);
                expected_columns.push_back(col);
                clear_column();
            end
        endfunction

        function void check_column(cmmre_pkg::out_t got);
            cmmre_pkg::out_t want;
            if (expected_columns.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: min %0d max %0d rms %0d",
                             got.column_min, got.column_max, got.column_rms);
                return;
            end
            want = expected_columns.pop_front();
            if (got.column_min !== want.column_min || got.column_max !== want.column_max ||
                    got.column_rms !== want.column_rms) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"column mismatch: expected min %0d max %0d rms %0d, ",
                              "got min %0d max %0d rms %0d"},
                             want.column_min, want.column_max, want.column_rms,
                             got.column_min, got.column_max, got.column_rms);
            end
        endfunction
    endclass

    logic            aclk    = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    cmmre_pkg::in_t  s_data  = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    cmmre_pkg::out_t m_data;

    bit              calm = 1'b0;
    int unsigned     cycle_count = 0;
    column_envelope  envelope = new();

    column_min_max_rms_envelope_top #(
        .MAX_COLUMN_SAMPLES(COLUMN_BOUND)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: stall at random except in calm stretches, check every transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) envelope.check_column(m_data);
            m_ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    function automatic logic [cmmre_pkg::SAMPLE_W-1:0] random_sample();
        logic [cmmre_pkg::SAMPLE_W-1:0] v;
        case ($urandom_range(9))
            0: v = 16'h8000;
            1: v = 16'h7fff;
            2: v = '0;
            3, 4: v = 16'($urandom_range(64)) - 16'd32;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_sample(input logic [cmmre_pkg::SAMPLE_W-1:0] value,
                               input logic closes);
        cmmre_pkg::in_t item;
        item.sample         = value;
        item.last_in_column = closes;
        if (!calm && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < 24) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        envelope.take_sample(item);
    endtask

    initial begin
        int sent;
        int len;
        int pick;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-sample columns at the extremes
        send_sample(16'h0000, 1'b1);
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h8000, 1'b1);
        // full-scale negative column gives the largest RMS
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hffff, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b1);
        // positive only: min holds at zero
        send_sample(16'd100, 1'b0);
        send_sample(16'd200, 1'b1);
        // negative only: max holds at zero
        send_sample(-16'sd5, 1'b0);
        send_sample(-16'sd7, 1'b1);
        send_sample(16'h5555, 1'b0);
        send_sample(16'haaaa, 1'b0);
        send_sample(16'h0000, 1'b1);

        // long column sent back to back, then closed by one more sample
        calm = 1'b1;
        for (int k = 0; k < LONG_COLUMN; k++) send_sample(random_sample(), 1'b0);
        calm = 1'b0;
        send_sample(16'h1234, 1'b1);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = (sent >= 450 && sent < 800);
            pick = $urandom_range(9);
            if (pick < 3) len = 1;
            else if (pick < 7) len = $urandom_range(8, 2);
            else len = $urandom_range(64, 9);
            for (int k = 0; k < len; k++) send_sample(random_sample(), k == len - 1);
            sent += len;
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (envelope.expected_columns.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (envelope.failures == 0 && envelope.expected_columns.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/cmmre_pkg.sv
hw/rtl/cmmre_front.sv
hw/rtl/cmmre_fifo.sv
hw/rtl/cmmre_back.sv
hw/rtl/column_min_max_rms_envelope_top.sv
dv/tb.sv
